[sv/sensor_minmax_calibrate_normalize_assert.svh]
// Assertion macros for the sensor min/max calibration block.
// Taken in by the modules that carry concurrent checks; needs nothing else.
`ifndef SENSOR_MINMAX_CALIBRATE_NORMALIZE_ASSERT_SVH
`define SENSOR_MINMAX_CALIBRATE_NORMALIZE_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define SMCN_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// pre holds -> post holds in the next cycle
`define SMCN_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/smcn_pkg.sv]
// Shared types and constants of the sensor min/max calibration block.
// Used by the register file, controller, datapath and top level.
`default_nettype none

package smcn_pkg;

   // item field widths
   localparam int MODE_W      = 3;
   localparam int IDX_W       = 6;
   localparam int MV_W        = 12;
   localparam int NORM_W      = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // bounds and arithmetic
   localparam int BOUND_W   = 24;
   localparam int MARGIN_W  = 16;
   localparam int FACTOR_W  = 17;
   localparam int INV_W     = 24;
   localparam int Q_FRAC    = 12;
   localparam int DIV_STEPS = 16;
   localparam int STEP_W    = 4;

   localparam logic [BOUND_W-1:0]  BOUND_MAX = 24'hFF_FFFF;
   localparam logic [FACTOR_W-1:0] ONE_Q16   = 17'h1_0000;
   localparam logic [NORM_W-1:0]   NORM_MAX  = 16'h7FFF;
   localparam logic [NORM_W-1:0]   NORM_MIN  = 16'h8000;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_METHOD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_MARGIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_MARGIN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERSE_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_LOW   = 3'd4;

   localparam logic [MV_W-1:0] INITIAL_LOW_RESET = 12'd3300;

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HIGH      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOW       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NORMALIZE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_VERIFY    = 3'd4;

   typedef struct packed {
      logic                calib_method;
      logic [MARGIN_W-1:0] high_margin;
      logic [MARGIN_W-1:0] low_margin;
      logic [INV_W-1:0]    inverse_count;
      logic [MV_W-1:0]     initial_low;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CLEAR,
      S_PK_MHI,
      S_PK_UHI,
      S_PK_MLO,
      S_PK_ULO,
      S_MN_MUL,
      S_MN_INV,
      S_MN_ADD,
      S_DIV_INIT,
      S_DIV_CHK,
      S_DIV_STEP,
      S_DONE
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_CLEAR,
      OP_MUL,
      OP_MUL_INV,
      OP_PEAK,
      OP_MEAN,
      OP_DIV_INIT,
      OP_DIV_CHK,
      OP_DIV_STEP,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      use_low;   // select low bound / low margin
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              method;
      logic              in_range;
      logic              fault;
      logic              ov;
   } dp_status_type;

endpackage

`default_nettype wire

[sv/sensor_minmax_calibrate_normalize.sv]
// Sensor min/max calibration and normalization: one item in, one result out, one
// item at a time. Per item: clear resets the bounds; verify and an out-of-range
// index do no arithmetic; peak update makes two passes through the shared
// 12x17 multiplier; mean update does a 12x17 then a 29x24 multiply, then the
// saturating add; normalize runs 16 steps of the radix-2 divider, none when the
// quotient would be 2^16 or more or the entry is faulted. A finished item waits
// for the output register to be free before the next item is taken. Bounds live
// in a SENSORS-deep memory with one read and at most one write per item; per-entry
// valid bits cleared by reset make every entry read as zero until written, so no
// clearing pass is needed. Depends on smcn_pkg, smcn_csr, smcn_ctrl and smcn_dp.
`default_nettype none

module sensor_minmax_calibrate_normalize #(
   parameter int SENSORS         = 64,
   parameter int BOUND_FRAC_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input items
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [smcn_pkg::REQ_TDATA_W-1:0]    req_tdata,  // sensor_index[5:0], millivolts[17:6]
   input  wire logic [smcn_pkg::MODE_W-1:0]         req_tuser,  // mode[2:0]
   // results
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [smcn_pkg::RSP_TDATA_W-1:0]         rsp_tdata,  // sensor_id[5:0], normalized[21:6]
   output logic                                     rsp_tuser,  // cal_fault[0]
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [smcn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [smcn_pkg::CSR_DATA_W-1:0]     csr_data
);

   smcn_pkg::cfg_type        cfg;
   smcn_pkg::dp_cmd_type     cmd;
   smcn_pkg::dp_status_type  status;

   smcn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   smcn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smcn_dp #(
      .SENSORS         (SENSORS),
      .BOUND_FRAC_BITS (BOUND_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

[sv/smcn_csr.sv]
// Configuration registers of the sensor min/max calibration block.
// Depends on smcn_pkg for register indexes and the cfg_type bundle.
`default_nettype none

module smcn_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [smcn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [smcn_pkg::CSR_DATA_W-1:0]     csr_data,
   output smcn_pkg::cfg_type                        cfg
);

   smcn_pkg::cfg_type cfg_ff;
   smcn_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            smcn_pkg::REG_CALIB_METHOD:  cfg_in.calib_method  = csr_data[0];
            smcn_pkg::REG_HIGH_MARGIN:   cfg_in.high_margin   = csr_data[smcn_pkg::MARGIN_W-1:0];
            smcn_pkg::REG_LOW_MARGIN:    cfg_in.low_margin    = csr_data[smcn_pkg::MARGIN_W-1:0];
            smcn_pkg::REG_INVERSE_COUNT: cfg_in.inverse_count = csr_data[smcn_pkg::INV_W-1:0];
            smcn_pkg::REG_INITIAL_LOW:   cfg_in.initial_low   = csr_data[smcn_pkg::MV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calib_method  <= 1'b0;
         cfg_ff.high_margin   <= '0;
         cfg_ff.low_margin    <= '0;
         cfg_ff.inverse_count <= '0;
         cfg_ff.initial_low   <= smcn_pkg::INITIAL_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[sv/smcn_dp.sv]
// Datapath: bound memory, shared multipliers, saturation and the radix-2 divider.
// Depends on smcn_pkg; driven by smcn_ctrl through dp_cmd_type / dp_status_type.
`default_nettype none

module smcn_dp #(
   parameter int SENSORS         = 64,
   parameter int BOUND_FRAC_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire smcn_pkg::cfg_type                    cfg,
   input  wire smcn_pkg::dp_cmd_type                 cmd,
   output smcn_pkg::dp_status_type                   status,
   input  wire logic [smcn_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic [smcn_pkg::MODE_W-1:0]          req_tuser,
   output logic [smcn_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                      rsp_tuser
);

   localparam int BOUND_W   = smcn_pkg::BOUND_W;
   localparam int MV_W      = smcn_pkg::MV_W;
   localparam int IDX_W     = smcn_pkg::IDX_W;
   localparam int MODE_W    = smcn_pkg::MODE_W;
   localparam int NORM_W    = smcn_pkg::NORM_W;
   localparam int FACTOR_W  = smcn_pkg::FACTOR_W;
   localparam int INV_W     = smcn_pkg::INV_W;
   localparam int Q_FRAC    = smcn_pkg::Q_FRAC;
   localparam int DIV_STEPS = smcn_pkg::DIV_STEPS;
   localparam int MARGIN_W  = smcn_pkg::MARGIN_W;

   localparam int ADDR_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int SAMPLE_W = MV_W + BOUND_FRAC_BITS;
   localparam int MAG_W    = (SAMPLE_W > BOUND_W) ? SAMPLE_W : BOUND_W;
   localparam int NUM_W    = MAG_W + Q_FRAC;
   localparam int CMP_W    = BOUND_W + DIV_STEPS;
   localparam int PROD_W   = MV_W + FACTOR_W;
   localparam int PEAK_SH  = MARGIN_W - BOUND_FRAC_BITS;
   localparam int PROD2_W  = PROD_W + INV_W;
   localparam int MEAN_SH  = MARGIN_W + INV_W - BOUND_FRAC_BITS;
   localparam int INC_W    = PROD2_W - MEAN_SH;
   localparam int SUM_W    = ((INC_W > BOUND_W) ? INC_W : BOUND_W) + 1;

   // item registers
   logic [MODE_W-1:0]     mode_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [MV_W-1:0]       mv_ff;
   logic                  in_range_ff;

   // bound memory, one row holds {high, low}
   logic [2*BOUND_W-1:0]  bound_mem [SENSORS];
   logic [SENSORS-1:0]    valid_ff;
   logic [2*BOUND_W-1:0]  rd_ff;
   logic                  rd_valid_ff;

   // working registers
   logic [BOUND_W-1:0]    hi_ff;
   logic [BOUND_W-1:0]    lo_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [PROD2_W-1:0]    prod2_ff;
   logic                  neg_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic [BOUND_W-1:0]    den_ff;
   logic                  ov_ff;
   logic [BOUND_W-1:0]    rem_ff;
   logic [DIV_STEPS-1:0]  numlo_ff;
   logic [DIV_STEPS-1:0]  quo_ff;

   logic [IDX_W-1:0]      rsp_id_ff;
   logic [NORM_W-1:0]     rsp_norm_ff;
   logic                  rsp_fault_ff;

   // combinational
   logic [IDX_W-1:0]      req_idx;
   logic [MV_W-1:0]       req_mv;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SAMPLE_W-1:0]   sample;
   logic [MAG_W-1:0]      sample_x;
   logic [FACTOR_W-1:0]   factor;
   logic [PROD_W-1:0]     prod_in;
   logic [PROD_W-1:0]     peak_sh;
   logic [BOUND_W-1:0]    peak_val;
   logic [PROD2_W-1:0]    prod2_in;
   logic [INC_W-1:0]      inc;
   logic [SUM_W-1:0]      mean_sum;
   logic [BOUND_W-1:0]    mean_val;
   logic [SAMPLE_W-1:0]   clr_sh;
   logic [BOUND_W-1:0]    clr_lo;
   logic                  fault;
   logic [NUM_W-1:0]      num;
   logic [BOUND_W:0]      trial;
   logic                  trial_ge;
   logic [NORM_W-1:0]     norm_sat;
   logic [NORM_W-1:0]     norm_out;

   assign req_idx  = req_tdata[IDX_W-1:0];
   assign req_mv   = req_tdata[IDX_W +: MV_W];
   assign rd_addr  = ADDR_W'(req_idx);
   assign wr_addr  = ADDR_W'(idx_ff);

   assign sample   = SAMPLE_W'(mv_ff) << BOUND_FRAC_BITS;
   assign sample_x = MAG_W'(sample);

   assign factor = cmd.use_low ? (smcn_pkg::ONE_Q16 - FACTOR_W'(cfg.low_margin))
                               : (smcn_pkg::ONE_Q16 + FACTOR_W'(cfg.high_margin));
   assign prod_in = PROD_W'(mv_ff) * PROD_W'(factor);

   assign peak_sh  = prod_ff >> PEAK_SH;
   assign peak_val = (peak_sh > PROD_W'(smcn_pkg::BOUND_MAX)) ? smcn_pkg::BOUND_MAX
                                                              : peak_sh[BOUND_W-1:0];

   assign prod2_in = PROD2_W'(prod_ff) * PROD2_W'(cfg.inverse_count);
   assign inc      = INC_W'(prod2_ff >> MEAN_SH);
   assign mean_sum = SUM_W'(inc) + SUM_W'(cmd.use_low ? lo_ff : hi_ff);
   assign mean_val = (mean_sum > SUM_W'(smcn_pkg::BOUND_MAX)) ? smcn_pkg::BOUND_MAX
                                                              : mean_sum[BOUND_W-1:0];

   assign clr_sh = SAMPLE_W'(cfg.initial_low) << BOUND_FRAC_BITS;
   always_comb begin
      if (cfg.calib_method) begin
         clr_lo = '0;
      end else if (MAG_W'(clr_sh) > MAG_W'(smcn_pkg::BOUND_MAX)) begin
         clr_lo = smcn_pkg::BOUND_MAX;
      end else begin
         clr_lo = BOUND_W'(clr_sh);
      end
   end

   assign fault = !(hi_ff > lo_ff);

   // divider: numerator is |sample - low| scaled to Q12
   assign num      = {mag_ff, {Q_FRAC{1'b0}}};
   assign trial    = {rem_ff, numlo_ff[DIV_STEPS-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_comb begin
      if (ov_ff) begin
         norm_sat = neg_ff ? smcn_pkg::NORM_MIN : smcn_pkg::NORM_MAX;
      end else if (neg_ff) begin
         norm_sat = quo_ff[DIV_STEPS-1] ? smcn_pkg::NORM_MIN : NORM_W'(~quo_ff + 1'b1);
      end else begin
         norm_sat = quo_ff[DIV_STEPS-1] ? smcn_pkg::NORM_MAX : NORM_W'(quo_ff);
      end
   end

   assign norm_out = (mode_ff == smcn_pkg::MODE_NORMALIZE && in_range_ff && !fault)
                   ? norm_sat : '0;

   assign status.mode     = mode_ff;
   assign status.method   = cfg.calib_method;
   assign status.in_range = in_range_ff;
   assign status.fault    = fault;
   assign status.ov       = ov_ff;

   assign rsp_tdata = {{(smcn_pkg::RSP_TDATA_W - NORM_W - IDX_W){1'b0}}, rsp_norm_ff, rsp_id_ff};
   assign rsp_tuser = rsp_fault_ff;

   // entry valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.op == smcn_pkg::OP_FINISH && in_range_ff) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == smcn_pkg::OP_CAPTURE) begin
         rd_ff       <= bound_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.op == smcn_pkg::OP_FINISH && in_range_ff) begin
         bound_mem[wr_addr] <= {hi_ff, lo_ff};
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         smcn_pkg::OP_CAPTURE: begin
            mode_ff     <= req_tuser;
            idx_ff      <= req_idx;
            mv_ff       <= req_mv;
            in_range_ff <= 32'(req_idx) < 32'(SENSORS);
         end
         smcn_pkg::OP_LOAD: begin
            hi_ff <= rd_valid_ff ? rd_ff[2*BOUND_W-1:BOUND_W] : '0;
            lo_ff <= rd_valid_ff ? rd_ff[BOUND_W-1:0] : '0;
         end
         smcn_pkg::OP_CLEAR: begin
            hi_ff <= '0;
            lo_ff <= clr_lo;
         end
         smcn_pkg::OP_MUL: begin
            prod_ff <= prod_in;
         end
         smcn_pkg::OP_MUL_INV: begin
            prod2_ff <= prod2_in;
         end
         smcn_pkg::OP_PEAK: begin
            if (cmd.use_low) begin
               if (sample_x < MAG_W'(lo_ff)) lo_ff <= peak_val;
            end else begin
               if (sample_x > MAG_W'(hi_ff)) hi_ff <= peak_val;
            end
         end
         smcn_pkg::OP_MEAN: begin
            if (cmd.use_low) lo_ff <= mean_val;
            else             hi_ff <= mean_val;
         end
         smcn_pkg::OP_DIV_INIT: begin
            neg_ff <= sample_x < MAG_W'(lo_ff);
            mag_ff <= (sample_x < MAG_W'(lo_ff)) ? (MAG_W'(lo_ff) - sample_x)
                                                 : (sample_x - MAG_W'(lo_ff));
            den_ff <= hi_ff - lo_ff;
         end
         smcn_pkg::OP_DIV_CHK: begin
            // quotient of 2^16 or more saturates either way
            ov_ff    <= CMP_W'(num) >= {den_ff, {DIV_STEPS{1'b0}}};
            rem_ff   <= BOUND_W'(num >> DIV_STEPS);
            numlo_ff <= num[DIV_STEPS-1:0];
            quo_ff   <= '0;
         end
         smcn_pkg::OP_DIV_STEP: begin
            rem_ff   <= trial_ge ? BOUND_W'(trial - {1'b0, den_ff}) : BOUND_W'(trial);
            numlo_ff <= numlo_ff << 1;
            quo_ff   <= {quo_ff[DIV_STEPS-2:0], trial_ge};
         end
         smcn_pkg::OP_FINISH: begin
            rsp_id_ff    <= idx_ff;
            rsp_norm_ff  <= norm_out;
            rsp_fault_ff <= !in_range_ff || fault;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[sv/smcn_ctrl.sv]
// Controller state machine: sequences the datapath per item mode and owns the
// handshakes. Depends on smcn_pkg and the assertion macro header.
`default_nettype none

`include "sensor_minmax_calibrate_normalize_assert.svh"

module smcn_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire smcn_pkg::dp_status_type  status,
   output smcn_pkg::dp_cmd_type          cmd
);

   localparam logic [smcn_pkg::STEP_W-1:0] STEP_LAST = smcn_pkg::STEP_W'(smcn_pkg::DIV_STEPS - 1);

   smcn_pkg::ctl_state_type          state_ff;
   smcn_pkg::ctl_state_type          state_in;
   logic [smcn_pkg::STEP_W-1:0]      step_ff;
   logic [smcn_pkg::STEP_W-1:0]      step_in;
   logic                             rsp_tvalid_ff;
   logic                             rsp_tvalid_in;
   logic                             finish;

   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smcn_pkg::S_IDLE;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = '0;
      req_tready  = 1'b0;
      finish      = 1'b0;
      cmd.op      = smcn_pkg::OP_NONE;
      cmd.use_low = 1'b0;
      case (state_ff)
         smcn_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = smcn_pkg::OP_CAPTURE;
               state_in = smcn_pkg::S_LOAD;
            end
         end
         smcn_pkg::S_LOAD: begin
            cmd.op = smcn_pkg::OP_LOAD;
            if (!status.in_range) begin
               state_in = smcn_pkg::S_DONE;
            end else begin
               case (status.mode)
                  smcn_pkg::MODE_CLEAR: state_in = smcn_pkg::S_CLEAR;
                  smcn_pkg::MODE_HIGH,
                  smcn_pkg::MODE_LOW:
                     state_in = status.method ? smcn_pkg::S_MN_MUL : smcn_pkg::S_PK_MHI;
                  smcn_pkg::MODE_NORMALIZE: state_in = smcn_pkg::S_DIV_INIT;
                  default: state_in = smcn_pkg::S_DONE;
               endcase
            end
         end
         smcn_pkg::S_CLEAR: begin
            cmd.op   = smcn_pkg::OP_CLEAR;
            state_in = smcn_pkg::S_DONE;
         end
         smcn_pkg::S_PK_MHI: begin
            cmd.op   = smcn_pkg::OP_MUL;
            state_in = smcn_pkg::S_PK_UHI;
         end
         smcn_pkg::S_PK_UHI: begin
            cmd.op   = smcn_pkg::OP_PEAK;
            state_in = smcn_pkg::S_PK_MLO;
         end
         smcn_pkg::S_PK_MLO: begin
            cmd.op      = smcn_pkg::OP_MUL;
            cmd.use_low = 1'b1;
            state_in    = smcn_pkg::S_PK_ULO;
         end
         smcn_pkg::S_PK_ULO: begin
            cmd.op      = smcn_pkg::OP_PEAK;
            cmd.use_low = 1'b1;
            state_in    = smcn_pkg::S_DONE;
         end
         smcn_pkg::S_MN_MUL: begin
            cmd.op      = smcn_pkg::OP_MUL;
            cmd.use_low = status.mode == smcn_pkg::MODE_LOW;
            state_in    = smcn_pkg::S_MN_INV;
         end
         smcn_pkg::S_MN_INV: begin
            cmd.op   = smcn_pkg::OP_MUL_INV;
            state_in = smcn_pkg::S_MN_ADD;
         end
         smcn_pkg::S_MN_ADD: begin
            cmd.op      = smcn_pkg::OP_MEAN;
            cmd.use_low = status.mode == smcn_pkg::MODE_LOW;
            state_in    = smcn_pkg::S_DONE;
         end
         smcn_pkg::S_DIV_INIT: begin
            if (status.fault) begin
               state_in = smcn_pkg::S_DONE;
            end else begin
               cmd.op   = smcn_pkg::OP_DIV_INIT;
               state_in = smcn_pkg::S_DIV_CHK;
            end
         end
         smcn_pkg::S_DIV_CHK: begin
            cmd.op   = smcn_pkg::OP_DIV_CHK;
            state_in = smcn_pkg::S_DIV_STEP;
         end
         smcn_pkg::S_DIV_STEP: begin
            if (status.ov) begin
               state_in = smcn_pkg::S_DONE;
            end else begin
               cmd.op  = smcn_pkg::OP_DIV_STEP;
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_LAST) begin
                  step_in  = '0;
                  state_in = smcn_pkg::S_DONE;
               end
            end
         end
         smcn_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.op   = smcn_pkg::OP_FINISH;
               finish   = 1'b1;
               state_in = smcn_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = smcn_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (finish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   `SMCN_ASSERT_NEXT(a_accept_loads, clock, reset, req_tvalid && req_tready,
      state_ff == smcn_pkg::S_LOAD, "accepted item did not move to bound load")
   `SMCN_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.op == smcn_pkg::OP_FINISH,
      !rsp_tvalid_ff || rsp_tready, "result written over a pending item")
   `SMCN_ASSERT_NEXT(a_finish_presents, clock, reset, cmd.op == smcn_pkg::OP_FINISH,
      rsp_tvalid_ff, "finished item not presented")
   `SMCN_ASSERT_IMPLY(a_step_idle, clock, reset, state_ff == smcn_pkg::S_IDLE,
      step_ff == '0, "divider step count not cleared between items")

endmodule

`default_nettype wire
